// ===== design/des_pkg.sv =====
// ----------------------------------------------------------------------------
// des_pkg
// Types, codes and the ordering function shared by the entry sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package des_pkg;

    localparam int ID_W       = 16;
    localparam int KEY_W      = 63;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

    localparam logic [1:0] KEY_SIZE  = 2'd0;
    localparam logic [1:0] KEY_MTIME = 2'd1;
    localparam logic [1:0] KEY_ATIME = 2'd2;
    localparam logic [1:0] KEY_CTIME = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic             is_dir;
        logic [KEY_W-1:0] size_key;
        logic [KEY_W-1:0] mtime_key;
        logic [KEY_W-1:0] atime_key;
        logic [KEY_W-1:0] ctime_key;
        logic             last;
    } des_in_t;

    typedef struct packed {
        logic [ID_W-1:0] out_id;
        logic            out_is_dir;
        logic            out_last;
        logic            overflow;
    } des_out_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic             dir;
        logic [KEY_W-1:0] key;
    } des_entry_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } des_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_SORT
    } des_op_t;

    typedef struct packed {
        des_op_t op;
        logic    descending;
    } des_ctrl_t;

    // true if a must be emitted strictly before b
    function automatic logic goes_before(input des_entry_t a, input des_entry_t b,
                                         input logic desc);
        logic res;
        if (a.dir != b.dir)
        begin
            res = a.dir;
        end
        else if (desc)
        begin
            res = (a.key > b.key);
        end
        else
        begin
            res = (a.key < b.key);
        end
        return res;
    endfunction

endpackage

// ===== design/des_cell.sv =====
// ----------------------------------------------------------------------------
// des_cell
// One slot of the sorting chain: shifts, or swaps with its upper or lower neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module des_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  des_pkg::des_ctrl_t  ctrl,
    input  logic                pair_en,
    input  logic                swap_dn,
    input  des_pkg::des_entry_t lower,
    input  des_pkg::des_entry_t upper,
    output des_pkg::des_entry_t entry,
    output logic                swap_up
);
    import des_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    des_entry_t data_reg;
    des_entry_t data_next;

    assign entry = '{valid: valid_reg, id: data_reg.id, dir: data_reg.dir, key: data_reg.key};

    assign swap_up = pair_en && valid_reg &&
                     (!upper.valid || goes_before(entry, upper, ctrl.descending));

    always_comb
    begin
        data_next = entry;
        case (ctrl.op)
            CELL_SHIFT:
            begin
                data_next = lower;
            end
            CELL_SORT:
            begin
                if (swap_up)
                begin
                    data_next = upper;
                end
                else if (swap_dn)
                begin
                    data_next = lower;
                end
            end
            default:
            begin
                data_next = entry;
            end
        endcase
        valid_next = data_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== design/directory_entry_sorter.sv =====
// ----------------------------------------------------------------------------
// directory_entry_sorter
// Loads a list of directory entries and emits it head first, then
// directories, then files, each group ordered by the configured key.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready) takes one word per cycle while loading. The
//   first word of a list is held as the head; later words shift into a row
//   of MAX_ENTRIES-1 cells. Words beyond capacity are dropped and every
//   result of that list carries overflow.
//   The word with last set ends the list. The row is then sorted by odd/even
//   exchange, then the out channel shows n words, one per cycle while
//   out_ready is high (n = stored entries). in_ready is low from the last
//   word until the final result is taken.
//   A stalled receiver simply holds the current result and the row.
//   Configuration (cfg_we, cfg_index, cfg_data) is written between lists;
//   the key choice is taken as each word loads.
//   Reset clears the fill count, overflow, configuration and cell valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directory_entry_sorter #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  des_pkg::des_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output des_pkg::des_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import des_pkg::*;

    localparam int CELLS = MAX_ENTRIES - 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int PH_W  = $clog2(MAX_ENTRIES);

    des_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             head_pend_reg, head_pend_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [1:0]       sort_key_reg;
    logic             desc_reg;
    logic [ID_W-1:0]  head_id_reg;
    logic             head_dir_reg;

    logic             in_acc;
    logic             store_ok;
    logic             head_wr;
    des_op_t          cell_op;
    des_ctrl_t        ctrl;
    logic [KEY_W-1:0] new_key;
    des_entry_t       shift_in;
    des_entry_t       empty_entry;
    des_entry_t       cell_q  [CELLS];
    logic             swap_up [CELLS];

    assign in_acc   = in_valid && in_ready;
    assign store_ok = (count_reg < CNT_W'(MAX_ENTRIES));
    assign head_wr  = in_acc && (count_reg == '0);

    always_comb
    begin
        unique case (sort_key_reg)
            KEY_SIZE:  new_key = in_data.size_key;
            KEY_MTIME: new_key = in_data.mtime_key;
            KEY_ATIME: new_key = in_data.atime_key;
            KEY_CTIME: new_key = in_data.ctime_key;
            default:   new_key = in_data.size_key;
        endcase
    end

    assign shift_in    = '{valid: (state_reg == ST_LOAD), id: in_data.entry_id,
                           dir: in_data.is_dir, key: new_key};
    assign empty_entry = '{valid: 1'b0, id: '0, dir: 1'b0, key: '0};
    assign ctrl        = '{op: cell_op, descending: desc_reg};

    // control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        head_pend_next = head_pend_reg;
        phase_next     = phase_reg;
        cell_op        = CELL_HOLD;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg != '0)
                        begin
                            cell_op = CELL_SHIFT;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_data.last)
                    begin
                        state_next     = ST_SORT;
                        phase_next     = '0;
                        head_pend_next = 1'b1;
                    end
                end
            end
            ST_SORT:
            begin
                cell_op    = CELL_SORT;
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_W'(CELLS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (head_pend_reg)
                    begin
                        head_pend_next = 1'b0;
                    end
                    else
                    begin
                        cell_op = CELL_SHIFT;
                    end
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            head_pend_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            head_pend_reg <= head_pend_next;
            phase_reg     <= phase_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_key_reg <= 2'd0;
            desc_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SORT_KEY:   sort_key_reg <= cfg_data[1:0];
                REG_DESCENDING: desc_reg     <= cfg_data[0];
                default:        desc_reg     <= desc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_wr)
        begin
            head_id_reg  <= in_data.entry_id;
            head_dir_reg <= in_data.is_dir;
        end
    end

    // chain of cells, best entry settles at the top
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic       pair_en;
        logic       swap_dn;
        des_entry_t lower;
        des_entry_t upper;

        if (i == 0)
        begin : g_bottom
            assign lower   = shift_in;
            assign swap_dn = 1'b0;
        end
        else
        begin : g_inner_lo
            assign lower   = cell_q[i-1];
            assign swap_dn = swap_up[i-1];
        end

        if (i == CELLS - 1)
        begin : g_top
            assign upper   = empty_entry;
            assign pair_en = 1'b0;
        end
        else
        begin : g_inner_hi
            assign upper   = cell_q[i+1];
            assign pair_en = (phase_reg[0] == 1'(i % 2));
        end

        des_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .pair_en (pair_en),
            .swap_dn (swap_dn),
            .lower   (lower),
            .upper   (upper),
            .entry   (cell_q[i]),
            .swap_up (swap_up[i])
        );
    end

    assign out_data = '{
        out_id:     head_pend_reg ? head_id_reg : cell_q[CELLS-1].id,
        out_is_dir: head_pend_reg ? head_dir_reg : cell_q[CELLS-1].dir,
        out_last:   (count_reg == CNT_W'(1)),
        overflow:   dropped_reg
    };

endmodule
